// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/srfp_pkg.sv =====
package srfp_pkg;

    localparam int MAX_HORIZON = 64;
    localparam int MAX_MOVES   = 16;
    localparam int MAX_COEFFS  = 64;

    // field widths
    localparam int ACT_W   = 2;
    localparam int IDX_W   = 6;
    localparam int VAL_W   = 16;
    localparam int ROW_W   = 6;
    localparam int SUM_W   = 40;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 48;
    localparam int CFG_W   = 7;
    localparam int CFG_I_W = 2;

    // counter and address widths
    localparam int H_W  = $clog2(MAX_HORIZON + 1);
    localparam int M_W  = $clog2(MAX_MOVES + 1);
    localparam int N_W  = $clog2(MAX_COEFFS + 1);
    localparam int T_W  = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1;
    localparam int CA_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

    // register reset values, held inside the allowed range
    localparam int H_RST = (MAX_HORIZON < 64) ? MAX_HORIZON : 64;
    localparam int M_RST = (MAX_MOVES < 16) ? MAX_MOVES : 16;
    localparam int N_RST = (MAX_COEFFS < 64) ? MAX_COEFFS : 64;

    // actions carried in tuser
    localparam logic [ACT_W-1:0] ACT_LOAD_COEF = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_MOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_I_W-1:0] CFG_HORIZON     = 2'd0;
    localparam logic [CFG_I_W-1:0] CFG_MOVE_COUNT  = 2'd1;
    localparam logic [CFG_I_W-1:0] CFG_COEFF_COUNT = 2'd2;

    // controls broadcast from the sequencer to the chain
    typedef struct packed {
        logic             clear;
        logic             step;
        logic             wr;
        logic [IDX_W-1:0] wr_index;
        logic [M_W-1:0]   move_count;
    } t_chain_ctl;

    // controls seen by one cell
    typedef struct packed {
        logic clear;
        logic step;
        logic wr;
        logic active;
    } t_cell_ctl;

endpackage

// ===== sv/srfp_cell.sv =====
// One tap: holds a move and a partial sum, adds move*coef to the sum from the right while active.
module srfp_cell (
    input  logic                                i_clk,
    input  srfp_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [srfp_pkg::VAL_W-1:0]   i_value,
    input  logic signed [srfp_pkg::VAL_W-1:0]   i_coef,
    input  logic signed [srfp_pkg::SUM_W-1:0]   i_sum,
    output logic signed [srfp_pkg::SUM_W-1:0]   o_sum
);

    logic signed [srfp_pkg::VAL_W-1:0]  r_move;
    logic signed [srfp_pkg::SUM_W-1:0]  r_sum;
    logic signed [srfp_pkg::PROD_W-1:0] w_prod;
    logic signed [srfp_pkg::SUM_W-1:0]  n_sum;

    assign w_prod = r_move * i_coef;

    always_comb begin
        if (i_ctl.active) begin
            n_sum = i_sum + srfp_pkg::SUM_W'(w_prod);
        end else begin
            n_sum = i_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_move <= i_value;
        end
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.step) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== sv/srfp_chain.sv =====
// Transposed-form row of cells; cell j weights the coefficient j steps back.
module srfp_chain (
    input  logic                                i_clk,
    input  srfp_pkg::t_chain_ctl                i_ctl,
    input  logic signed [srfp_pkg::VAL_W-1:0]   i_value,
    input  logic signed [srfp_pkg::VAL_W-1:0]   i_coef,
    output logic signed [srfp_pkg::SUM_W-1:0]   o_sum
);

    logic signed [srfp_pkg::SUM_W-1:0] w_sum [srfp_pkg::MAX_MOVES+1];

    assign w_sum[srfp_pkg::MAX_MOVES] = '0;

    for (genvar j = 0; j < srfp_pkg::MAX_MOVES; j++) begin : g_cell
        srfp_pkg::t_cell_ctl w_ctl;

        always_comb begin
            w_ctl.clear  = i_ctl.clear;
            w_ctl.step   = i_ctl.step;
            w_ctl.wr     = i_ctl.wr && (int'(i_ctl.wr_index) == j);
            w_ctl.active = (j < int'(i_ctl.move_count));
        end

        srfp_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (i_value),
            .i_coef  (i_coef),
            .i_sum   (w_sum[j+1]),
            .o_sum   (w_sum[j])
        );
    end

    assign o_sum = w_sum[0];

endmodule

// ===== sv/step_response_forced_prediction.sv =====
// Channel    | Dir | Handshake                     | Word
// -----------+-----+-------------------------------+------------------------------------
// s_axis     | in  | s_axis_tvalid / s_axis_tready | tdata: index, value; tuser: action
// m_axis     | out | m_axis_tvalid / m_axis_tready | tdata: row, predicted; tlast; tuser
// cfg        | in  | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// Loads are taken in the idle state. A compute word runs row by row through the horizon:
// per row one coefficient memory read, one chain step, one move into the output register.
// An error word is accepted in the idle state and issued from the error state.
// Reset (i_rst_n low, synchronous) restores horizon 64, move count 16, coeff count 64
// and empties the output register; the stores keep their contents.
// An output stall holds the sequencer in its output and error states; input is taken only between compute runs.
module step_response_forced_prediction (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [srfp_pkg::IN_W-1:0]            s_axis_tdata,  // [5:0] index, [21:6] value
    input  logic [srfp_pkg::ACT_W-1:0]           s_axis_tuser,  // [1:0] action
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [srfp_pkg::OUT_W-1:0]           m_axis_tdata,  // [5:0] row, [45:6] predicted
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tuser,  // [0] error
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [srfp_pkg::CFG_I_W-1:0]         i_cfg_index,
    input  logic [srfp_pkg::CFG_W-1:0]           i_cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ERR  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_MAC  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                         r_state, n_state;
    logic [srfp_pkg::T_W-1:0]           r_t;
    logic [srfp_pkg::H_W-1:0]           r_horizon;
    logic [srfp_pkg::M_W-1:0]           r_moves;
    logic [srfp_pkg::N_W-1:0]           r_ncoef;

    // coefficient store, registered read
    logic signed [srfp_pkg::VAL_W-1:0]  r_coef_mem [srfp_pkg::MAX_COEFFS];
    logic signed [srfp_pkg::VAL_W-1:0]  r_coef;
    logic [srfp_pkg::CA_W-1:0]          w_rd_addr;

    // output register
    logic                               r_out_valid;
    logic [srfp_pkg::ROW_W-1:0]         r_out_row;
    logic signed [srfp_pkg::SUM_W-1:0]  r_out_pred;
    logic                               r_out_last;
    logic                               r_out_err;

    logic                               w_in_acc;
    logic                               w_out_free;
    logic                               w_last_row;
    logic [srfp_pkg::ACT_W-1:0]         w_action;
    logic [srfp_pkg::IDX_W-1:0]         w_index;
    logic signed [srfp_pkg::VAL_W-1:0]  w_value;
    logic signed [srfp_pkg::SUM_W-1:0]  w_chain_sum;
    srfp_pkg::t_chain_ctl               w_chain_ctl;

    assign w_action = s_axis_tuser;
    assign w_index  = s_axis_tdata[srfp_pkg::IDX_W-1:0];
    assign w_value  = signed'(s_axis_tdata[srfp_pkg::IDX_W +: srfp_pkg::VAL_W]);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_last_row    = (int'(r_t) + 1 == int'(r_horizon));
    assign o_cfg_ready   = 1'b1;

    // ---------------- configuration registers, clamped on write ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horizon <= srfp_pkg::H_W'(srfp_pkg::H_RST);
            r_moves   <= srfp_pkg::M_W'(srfp_pkg::M_RST);
            r_ncoef   <= srfp_pkg::N_W'(srfp_pkg::N_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                srfp_pkg::CFG_HORIZON: begin
                    if (i_cfg_data == '0) begin
                        r_horizon <= srfp_pkg::H_W'(1);
                    end else if (int'(i_cfg_data) > srfp_pkg::MAX_HORIZON) begin
                        r_horizon <= srfp_pkg::H_W'(srfp_pkg::MAX_HORIZON);
                    end else begin
                        r_horizon <= srfp_pkg::H_W'(i_cfg_data);
                    end
                end
                srfp_pkg::CFG_MOVE_COUNT: begin
                    // register is 5 bits wide
                    if (i_cfg_data[4:0] == '0) begin
                        r_moves <= srfp_pkg::M_W'(1);
                    end else if (int'(i_cfg_data[4:0]) > srfp_pkg::MAX_MOVES) begin
                        r_moves <= srfp_pkg::M_W'(srfp_pkg::MAX_MOVES);
                    end else begin
                        r_moves <= srfp_pkg::M_W'(i_cfg_data[4:0]);
                    end
                end
                srfp_pkg::CFG_COEFF_COUNT: begin
                    if (i_cfg_data == '0) begin
                        r_ncoef <= srfp_pkg::N_W'(1);
                    end else if (int'(i_cfg_data) > srfp_pkg::MAX_COEFFS) begin
                        r_ncoef <= srfp_pkg::N_W'(srfp_pkg::MAX_COEFFS);
                    end else begin
                        r_ncoef <= srfp_pkg::N_W'(i_cfg_data);
                    end
                end
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    // ---------------- coefficient store ----------------
    // Past the model length the last coefficient is reused.
    always_comb begin
        if (int'(r_t) >= int'(r_ncoef)) begin
            w_rd_addr = srfp_pkg::CA_W'(r_ncoef - 1'b1);
        end else begin
            w_rd_addr = srfp_pkg::CA_W'(r_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_action == srfp_pkg::ACT_LOAD_COEF)
                && (int'(w_index) < srfp_pkg::MAX_COEFFS)) begin
            r_coef_mem[srfp_pkg::CA_W'(w_index)] <= w_value;
        end
        r_coef <= r_coef_mem[w_rd_addr];
    end

    // ---------------- cell chain ----------------
    // Coefficient k is broadcast at step k; the sum leaving cell 0 after step t
    // is row t. Moves beyond the store depth never match a cell and are dropped.
    always_comb begin
        w_chain_ctl.clear      = w_in_acc && (w_action == srfp_pkg::ACT_COMPUTE);
        w_chain_ctl.step       = (r_state == ST_MAC);
        w_chain_ctl.wr         = w_in_acc && (w_action == srfp_pkg::ACT_LOAD_MOVE);
        w_chain_ctl.wr_index   = w_index;
        w_chain_ctl.move_count = r_moves;
    end

    srfp_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_chain_ctl),
        .i_value (w_value),
        .i_coef  (r_coef),
        .o_sum   (w_chain_sum)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (w_action == srfp_pkg::ACT_COMPUTE)) begin
                    n_state = (r_moves > r_horizon) ? ST_ERR : ST_RD;
                end
            end
            ST_ERR: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD:  n_state = ST_MAC;
            ST_MAC: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = w_last_row ? ST_IDLE : ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_t     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_t <= '0;
            end else if ((r_state == ST_OUT) && w_out_free) begin
                r_t <= r_t + 1'b1;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (((r_state == ST_OUT) || (r_state == ST_ERR)) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_row  <= srfp_pkg::ROW_W'(r_t);
            r_out_pred <= w_chain_sum;
            r_out_last <= w_last_row;
            r_out_err  <= 1'b0;
        end else if ((r_state == ST_ERR) && w_out_free) begin
            r_out_row  <= '0;
            r_out_pred <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = srfp_pkg::OUT_W'({r_out_pred, r_out_row});
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_err;

endmodule

// ===== sv/srfp_checker.sv =====
`include "assert_macros.svh"

module srfp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [srfp_pkg::OUT_W-1:0]       m_axis_tdata,
    input logic                             m_axis_tlast,
    input logic                             m_axis_tuser
);

    // an error word is a run by itself
    `CHK_SAME(a_err_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "error word without tlast")

    // an error word carries row 0 and a zero prediction
    `CHK_SAME(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error word with data")

    // mid-run rows pending means the sequencer is busy, no input taken
    `CHK_SAME(a_run_busy, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready inside a run")

    // a stalled word holds
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")

endmodule

bind step_response_forced_prediction srfp_checker u_srfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
